/* rtl/gam_pkg.sv */
// shared types, constants and constant tables for the rgb gamma correction block
// log2 tables are built at elaboration by constant functions; depends on nothing
package gam_pkg;

	localparam int CH_BITS   = 8;
	localparam int CH_MAX    = (1 << CH_BITS) - 1;
	localparam int NUM_CH    = 3;
	localparam int FRAC_BITS = 50;
	localparam int LOG_W     = 64;
	localparam int GAM_W     = 11;
	localparam int TAB_N     = 1 << CH_BITS;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_RED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE  = 2'd2;

	localparam logic [GAM_W-1:0] GAM_RESET = 11'd100;

	typedef logic [LOG_W-1:0] tab_t [TAB_N];

	typedef struct packed {
		logic [CH_BITS-1:0] red_in;
		logic [CH_BITS-1:0] green_in;
		logic [CH_BITS-1:0] blue_in;
	} pix_in_t;

	typedef struct packed {
		logic [CH_BITS-1:0] red_out;
		logic [CH_BITS-1:0] green_out;
		logic [CH_BITS-1:0] blue_out;
	} pix_out_t;

	typedef logic [NUM_CH-1:0][GAM_W-1:0] gam_vec_t;

	// per channel search state
	typedef struct packed {
		logic [LOG_W-1:0]   lhs;
		logic [CH_BITS-1:0] acc;
		logic               ovr;
		logic [CH_BITS-1:0] ovr_val;
	} chan_t;

	typedef struct packed {
		logic [CH_BITS-1:0]     probe;
		chan_t [NUM_CH-1:0]     ch;
	} stg_t;

	// log2(n) in q50, mantissa squared in q62
	function automatic logic [LOG_W-1:0] log2_fixed(input int unsigned n);
		logic [63:0]  m;
		logic [127:0] p;
		logic [63:0]  frac;
		int unsigned  ip;
		ip = 0;
		for (int i = 0; i < 31; i++) begin
			if ((n >> (ip + 1)) != 0) ip = ip + 1;
		end
		m = 64'(n) << (62 - ip);
		frac = '0;
		for (int i = 0; i < FRAC_BITS; i++) begin
			p = 128'(m) * 128'(m);
			m = p[125:62];
			frac = frac << 1;
			if (m[63]) begin
				frac[0] = 1'b1;
				m = m >> 1;
			end
		end
		return (64'(ip) << FRAC_BITS) | frac;
	endfunction

	// log2(max) - log2(v)
	function automatic tab_t build_ltab();
		tab_t        t;
		logic [63:0] lf;
		lf = log2_fixed(CH_MAX);
		for (int v = 0; v < TAB_N; v++) begin
			t[v] = (v == 0) ? '0 : lf - log2_fixed(v);
		end
		return t;
	endfunction

	// 100 * (log2(2 max) - log2(2k - 1)), threshold for output code k
	function automatic tab_t build_rtab();
		tab_t        t;
		logic [63:0] l2;
		l2 = log2_fixed(2 * CH_MAX);
		for (int k = 0; k < TAB_N; k++) begin
			t[k] = (k == 0) ? '0 : 64'(100) * (l2 - log2_fixed(2 * k - 1));
		end
		return t;
	endfunction

	localparam tab_t LTAB = build_ltab();
	localparam tab_t RTAB = build_rtab();

endpackage

/* rtl/gam_prep.sv */
// front of the pipeline: special cases, log table lookup, exponent multiply
// depends on gam_pkg
module gam_prep (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  gam_pkg::pix_in_t  in_data,
	input  gam_pkg::gam_vec_t gam,
	output logic              up_ready,
	input  logic              down_ready,
	output logic              valid_s2,
	output gam_pkg::stg_t     data_s2,
	output logic              valid_s1
);
	import gam_pkg::*;

	logic [NUM_CH-1:0][CH_BITS-1:0] v;
	logic [NUM_CH-1:0][LOG_W-1:0]   lt_s1;
	logic [NUM_CH-1:0][GAM_W-2:0]   g_s1;
	logic [NUM_CH-1:0]              ovr_s1;
	logic [NUM_CH-1:0][CH_BITS-1:0] ovr_val_s1;
	logic                           ready_s2;

	assign v[0] = in_data.red_in;
	assign v[1] = in_data.green_in;
	assign v[2] = in_data.blue_in;

	assign ready_s2 = !valid_s2 || down_ready;
	assign up_ready = !valid_s1 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && in_valid) begin
			for (int c = 0; c < NUM_CH; c++) begin
				// non-positive exponent, full scale or zero input bypass the search
				ovr_s1[c]     <= gam[c][GAM_W-1] || (gam[c] == '0) ||
				                 (v[c] == CH_BITS'(CH_MAX)) || (v[c] == '0);
				ovr_val_s1[c] <= (v[c] == '0 && !gam[c][GAM_W-1] && gam[c] != '0) ?
				                 '0 : CH_BITS'(CH_MAX);
				lt_s1[c]      <= LTAB[v[c]];
				g_s1[c]       <= gam[c][GAM_W-2:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			data_s2.probe <= CH_BITS'(1) << (CH_BITS - 1);
			for (int c = 0; c < NUM_CH; c++) begin
				data_s2.ch[c].lhs     <= LOG_W'(lt_s1[c] * g_s1[c]);
				data_s2.ch[c].acc     <= '0;
				data_s2.ch[c].ovr     <= ovr_s1[c];
				data_s2.ch[c].ovr_val <= ovr_val_s1[c];
			end
		end
	end

endmodule

/* rtl/gam_search.sv */
// one step of the output code search: decides one bit for all channels
// depends on gam_pkg
module gam_search (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  gam_pkg::stg_t in_data,
	output logic          up_ready,
	input  logic          down_ready,
	output logic          valid_s1,
	output gam_pkg::stg_t data_s1
);
	import gam_pkg::*;

	stg_t nxt;

	always_comb begin
		logic [CH_BITS-1:0] k;
		nxt = in_data;
		nxt.probe = in_data.probe >> 1;
		for (int c = 0; c < NUM_CH; c++) begin
			k = in_data.ch[c].acc | in_data.probe;
			// value at or above threshold k keeps the bit
			if (in_data.ch[c].lhs <= RTAB[k]) nxt.ch[c].acc = k;
		end
	end

	assign up_ready = !valid_s1 || down_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && in_valid) data_s1 <= nxt;
	end

endmodule

/* rtl/rgb_gamma_correction.sv */
// top level of the rgb gamma correction pipeline and its exponent registers
// depends on gam_pkg, gam_prep and gam_search
//
// Takes one pixel transaction per clock and returns one corrected pixel per
// transaction, in order. Each channel maps v to round(max * (v/max)^(g/100)),
// clamped to full scale, with g the channel's signed exponent in hundredths.
// The first prep register holds the log table lookup, the second the exponent
// multiply, and the search stages then decide the output bits msb first.
// Throughput is one pixel per clock while the output is not stalled; a stall
// at the output holds each stage only as far as it is occupied, so bubbles are
// squeezed out. Exponent registers reset to 100 (identity) and should be
// written while no transaction is in flight.
module rgb_gamma_correction (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  gam_pkg::pix_in_t                in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output gam_pkg::pix_out_t               out_data,
	input  logic                            cfg_we,
	input  logic [gam_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gam_pkg::GAM_W-1:0]       cfg_data
);
	import gam_pkg::*;

	gam_vec_t gam_q;

	// search chain: index 0 is the output of the prep stages
	logic [CH_BITS:0] vld;
	logic [CH_BITS:0] rdy;
	stg_t             stg [CH_BITS+1];
	logic             prep_up_ready;
	logic             prep_valid_s1;

	// exponent registers; indexes past blue are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gam_q <= {NUM_CH{GAM_RESET}};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RED:   gam_q[0] <= cfg_data;
				REG_GREEN: gam_q[1] <= cfg_data;
				REG_BLUE:  gam_q[2] <= cfg_data;
				default:   ;
			endcase
		end
	end

	gam_prep u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_data    (in_data),
		.gam        (gam_q),
		.up_ready   (prep_up_ready),
		.down_ready (rdy[0]),
		.valid_s2   (vld[0]),
		.data_s2    (stg[0]),
		.valid_s1   (prep_valid_s1)
	);

	// one search stage per output bit, msb first
	for (genvar i = 0; i < CH_BITS; i++) begin : g_search
		gam_search u_search (
			.clk        (clk),
			.arst_n     (arst_n),
			.in_valid   (vld[i]),
			.in_data    (stg[i]),
			.up_ready   (rdy[i]),
			.down_ready (rdy[i+1]),
			.valid_s1   (vld[i+1]),
			.data_s1    (stg[i+1])
		);
	end

	assign rdy[CH_BITS] = !out_stall;
	assign in_stall     = !prep_up_ready;
	assign out_valid    = vld[CH_BITS];

	// special cases override the searched code
	assign out_data.red_out   = stg[CH_BITS].ch[0].ovr ? stg[CH_BITS].ch[0].ovr_val
	                                                   : stg[CH_BITS].ch[0].acc;
	assign out_data.green_out = stg[CH_BITS].ch[1].ovr ? stg[CH_BITS].ch[1].ovr_val
	                                                   : stg[CH_BITS].ch[1].acc;
	assign out_data.blue_out  = stg[CH_BITS].ch[2].ovr ? stg[CH_BITS].ch[2].ovr_val
	                                                   : stg[CH_BITS].ch[2].acc;

	// an unstalled output never blocks the input
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled with free output");

	// an accepted transaction lands in the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> prep_valid_s1)
		else $error("accepted transaction lost at entry");

	// a held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed");

endmodule

/* test/gam_checker.sv */
// checker for rgb_gamma_correction: tracks exponent writes, predicts each corrected pixel
// and compares it with each output channel; depends on gam_pkg
`timescale 1ns / 100ps
module gam_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  gam_pkg::pix_in_t              in_data,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  gam_pkg::pix_out_t             out_data,
	input  logic                          cfg_we,
	input  logic [gam_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gam_pkg::GAM_W-1:0]     cfg_data,
	output int                            fail_count,
	output int                            pending
);
	import gam_pkg::*;

	localparam int LOG_N = 2 * CH_MAX + 1;

	logic [63:0]           log_q50 [LOG_N];
	logic signed [GAM_W-1:0] gamma_r, gamma_g, gamma_b;
	pix_out_t              corrected_q [$];

	// log2 of an integer, q50, fraction by repeated squaring of a q62 mantissa
	function automatic logic [63:0] log2_q50(input int unsigned n);
		int unsigned  msb;
		logic [63:0]  mant;
		logic [127:0] sq;
		logic [63:0]  frac;
		msb = 0;
		for (int b = 0; b < 31; b++)
			if (n >> (b + 1) != 0) msb = b + 1;
		mant = 64'(n) << (62 - msb);
		frac = '0;
		for (int i = 0; i < FRAC_BITS; i++) begin
			sq = {64'd0, mant} * {64'd0, mant};
			mant = sq[125:62];
			frac = {frac[62:0], mant[63]};
			if (mant[63]) mant = mant >> 1;
		end
		return (64'(msb) << FRAC_BITS) | frac;
	endfunction

	function automatic logic [CH_BITS-1:0] gamma_curve(input logic [CH_BITS-1:0] v,
			input logic signed [GAM_W-1:0] g);
		logic [63:0]        lhs, rhs;
		logic [CH_BITS-1:0] code;
		int unsigned        k;
		if (g <= 0 || v == CH_MAX) return CH_BITS'(CH_MAX);
		if (v == 0) return '0;
		lhs = (log_q50[CH_MAX] - log_q50[v]) * 64'(g);
		code = '0;
		for (int b = CH_BITS - 1; b >= 0; b--) begin
			k = code | (1 << b);
			rhs = 64'd100 * (log_q50[2 * CH_MAX] - log_q50[2 * k - 1]);
			if (lhs <= rhs) code = CH_BITS'(k);
		end
		return code;
	endfunction

	initial begin
		log_q50[0] = '0;
		for (int n = 1; n < LOG_N; n++) log_q50[n] = log2_q50(n);
	end

	always @(posedge clk or negedge arst_n) begin
		pix_out_t want;
		if (!arst_n) begin
			gamma_r <= GAM_RESET;
			gamma_g <= GAM_RESET;
			gamma_b <= GAM_RESET;
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_RED:   gamma_r <= cfg_data;
					REG_GREEN: gamma_g <= cfg_data;
					REG_BLUE:  gamma_b <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				want.red_out   = gamma_curve(in_data.red_in, gamma_r);
				want.green_out = gamma_curve(in_data.green_in, gamma_g);
				want.blue_out  = gamma_curve(in_data.blue_in, gamma_b);
				corrected_q.push_back(want);
			end
			if (out_valid && !out_stall) begin
				if (corrected_q.size() == 0) begin
					$error("unexpected output transaction %h", out_data);
					fail_count++;
				end else begin
					want = corrected_q.pop_front();
					if (out_data.red_out !== want.red_out) begin
						$error("red_out expected %0d actual %0d", want.red_out,
							out_data.red_out);
						fail_count++;
					end
					if (out_data.green_out !== want.green_out) begin
						$error("green_out expected %0d actual %0d", want.green_out,
							out_data.green_out);
						fail_count++;
					end
					if (out_data.blue_out !== want.blue_out) begin
						$error("blue_out expected %0d actual %0d", want.blue_out,
							out_data.blue_out);
						fail_count++;
					end
				end
			end
			pending = corrected_q.size();
		end
	end

endmodule

/* test/rgb_gamma_correction_tb.sv */
// stimulus and verdict for rgb_gamma_correction; drives pixels and exponent writes
// depends on gam_pkg, the block and gam_checker
`timescale 1ns / 100ps
module rgb_gamma_correction_tb;
	import gam_pkg::*;

	// index with no register behind it, writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int MAX_WAIT   = 17;
	localparam int IDLE_LIMIT = 4000;
	localparam int LATENCY    = 2 + CH_BITS;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	pix_in_t              in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b1;
	pix_out_t             out_data;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_RED;
	logic [GAM_W-1:0]     cfg_data = '0;
	int                   fail_count, pending;
	int                   pixels_sent = 0, settings_used = 0;
	int                   idle_cycles = 0;
	bit                   send_gaps = 1'b1, recv_gaps = 1'b1;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	rgb_gamma_correction u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	gam_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	// watchdog: any stretch without a transaction on either side is a hang
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout with %0d results outstanding", pending);
			$display("rgb_gamma_correction_tb NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver: random stall before each result, sometimes none at all
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = recv_gaps ? $urandom_range(0, MAX_WAIT) : 0;
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// one pixel transaction; valid stays high across back-to-back pixels
	task automatic send_pixel(input pix_in_t px);
		int gap;
		gap = send_gaps ? $urandom_range(0, MAX_WAIT) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= px;
		do @(posedge clk); while (in_stall);
		pixels_sent++;
	endtask

	// drain everything in flight, then load all three exponents
	task automatic load_gammas(input logic [GAM_W-1:0] r, g, b);
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (LATENCY + 2) @(posedge clk);
		cfg_we <= 1'b1; cfg_index <= REG_RED;   cfg_data <= r; @(posedge clk);
		cfg_index <= REG_GREEN; cfg_data <= g; @(posedge clk);
		cfg_index <= REG_BLUE;  cfg_data <= b; @(posedge clk);
		// unused index carries garbage that must not land anywhere
		cfg_index <= REG_UNUSED; cfg_data <= GAM_W'($urandom); @(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	task automatic random_pixels(input int count);
		repeat (count) send_pixel(pix_in_t'($urandom));
	endtask

	// extremes and bit patterns on every channel
	task automatic directed_pixels();
		pix_in_t corner [10];
		corner = '{'{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255},
			'{8'd1, 8'd254, 8'd128}, '{8'd254, 8'd1, 8'd127},
			'{8'h55, 8'hAA, 8'h0F}, '{8'hAA, 8'h55, 8'hF0},
			'{8'd0, 8'd255, 8'd1}, '{8'd255, 8'd0, 8'd2},
			'{8'd64, 8'd192, 8'd3}, '{8'd16, 8'd32, 8'd253}};
		foreach (corner[i]) send_pixel(corner[i]);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values give identity; then zero exponent, negative extremes,
		// positive extremes and a small exponent
		directed_pixels();
		load_gammas(11'd0, -11'sd1, -11'sd1024);
		directed_pixels();
		load_gammas(11'd1023, 11'd1000, -11'sd1000);
		directed_pixels();
		load_gammas(11'd1, 11'd50, 11'd220);
		directed_pixels();

		// gaps off on both sides for one stretch to run at full rate
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		random_pixels(120);
		send_gaps = 1'b1;
		recv_gaps = 1'b1;

		// random exponents over the full 11-bit range, mostly positive
		for (int phase = 0; phase < 8; phase++) begin
			if (phase % 3 == 0)
				load_gammas(GAM_W'($urandom), GAM_W'($urandom), GAM_W'($urandom));
			else
				load_gammas(GAM_W'($urandom_range(1, 400)),
					GAM_W'($urandom_range(1, 1023)), GAM_W'($urandom_range(1, 250)));
			if (phase == 5) send_gaps = 1'b0;
			if (phase == 6) recv_gaps = 1'b0;
			random_pixels(100);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (LATENCY + 4) @(posedge clk);

		$display("sent %0d pixels under %0d exponent settings, identity included",
			pixels_sent, settings_used + 1);
		if (fail_count == 0)
			$display("rgb_gamma_correction_tb OK");
		else
			$display("rgb_gamma_correction_tb NOT OK");
		$finish;
	end

endmodule
